/* rtl/closed_interval_set_merger_assert.svh */
// Assertion macros shared by the interval set RTL.
// Depends on nothing; included by closed_interval_set_merger.sv.
`ifndef CLOSED_INTERVAL_SET_MERGER_ASSERT_SVH
`define CLOSED_INTERVAL_SET_MERGER_ASSERT_SVH
`ifndef SYNTH
`define CISM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CISM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CISM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CISM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/cism_pkg.sv */
// Package for the closed interval set merger: payload structs, codes, constants.
// Depends on nothing.
`default_nettype none
package cism_pkg;
  localparam int MaxIntervals = 16;
  localparam int IdxBits = $clog2(MaxIntervals);
  localparam int CntBits = IdxBits + 1;
  localparam logic signed [31:0] PointHalf = 32'sd33423;

  typedef enum logic [2:0] {
    REQ_ADD   = 3'd0,
    REQ_POINT = 3'd1,
    REQ_QUERY = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_LIST  = 3'd4
  } req_code_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_value;
    logic signed [31:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic               entry_valid;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic               last;
  } out_item_t;
endpackage
`default_nettype wire

/* rtl/closed_interval_set_merger.sv */
// Top level of the closed interval set merger: one memory-based sequencer.
// Depends on cism_pkg and closed_interval_set_merger_assert.svh.
//
// Usage: drive in_item and raise start while busy is low; the request is
// transferred at that edge and busy rises at once. Results appear on out_item
// for one cycle each, marked by out_strobe; out_item.last flags the final one.
// The receiver cannot stall; every strobe is one transfer.
// Storage: the table lives in one memory of endpoint pairs with a registered
// read. An add rescans until the hull stops growing, then packs the table; a
// dropped add skips the pack pass. The single result, or the last list entry,
// is on the outputs in the cycle busy falls.
// Compaction writes entries back in place. When the hull is inserted ahead of
// an entry, that entry is held and later entries move up one slot;
// each write lands on the slot read at the same edge, which returns old data.
// Reset empties the table by clearing the count; memory is left as is.
`default_nettype none
`include "closed_interval_set_merger_assert.svh"
module closed_interval_set_merger (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  cism_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output cism_pkg::out_item_t out_item
);
  import cism_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PACK, S_QUERY, S_LIST, S_DONE
  } state_t;

  // Each memory word holds a low endpoint above a high endpoint.
  logic [63:0] mem [MaxIntervals];
  logic [63:0] rd_data_r;

  state_t state_r;
  logic [CntBits-1:0] count_r, rd_idx_r, wr_idx_r;
  logic [MaxIntervals-1:0] absorbed_r;
  logic signed [31:0] lo_r, hi_r;
  logic changed_r, any_r, placed_r, rd_vld_r, flag_r;
  logic [2:0] req_r;

  logic signed [31:0] m_lo, m_hi;
  logic [IdxBits-1:0] prev_idx;
  logic hit, absorb_now, place_now;
  assign m_lo = rd_data_r[63:32];
  assign m_hi = rd_data_r[31:0];
  assign prev_idx = rd_idx_r[IdxBits-1:0] - IdxBits'(1);
  assign hit = (m_lo <= hi_r) && (lo_r <= m_hi);
  assign absorb_now = rd_vld_r && !absorbed_r[prev_idx] && hit;
  // The hull goes ahead of the first kept entry that lies wholly above it.
  assign place_now = (state_r == S_PACK) && rd_vld_r && !absorbed_r[prev_idx]
                     && !placed_r && (m_lo > hi_r);
  assign busy = (state_r != S_IDLE);

  // Saturating point endpoints: i*65536 +- half fits in 49 bits.
  logic signed [48:0] pt_base, pt_lo, pt_hi;
  assign pt_base = {in_item.a_value[31], in_item.a_value, 16'd0};
  assign pt_lo = pt_base - 49'(PointHalf);
  assign pt_hi = pt_base + 49'(PointHalf);

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'sh7fffffff;
    if (v < -49'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [CntBits-1:0] rd_nxt;
  logic               mem_we;
  logic [IdxBits-1:0] mem_wa;
  logic [63:0]        mem_wd;

  // The read data is held while the hull is written ahead of it.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (!place_now) rd_data_r <= mem[rd_nxt[IdxBits-1:0]];
  end

  // Next read address and the pack write, from the current pass position.
  always_comb begin
    rd_nxt = '0;
    mem_we = 1'b0;
    mem_wa = wr_idx_r[IdxBits-1:0];
    mem_wd = {lo_r, hi_r};
    if (state_r inside {S_SCAN, S_PACK, S_QUERY, S_LIST}) rd_nxt = rd_idx_r;
    if (state_r == S_PACK && rd_vld_r && !absorbed_r[prev_idx]) begin
      mem_we = 1'b1;
      mem_wd = place_now ? {lo_r, hi_r} : rd_data_r;
    end
    if (state_r == S_PACK && !rd_vld_r && rd_idx_r >= count_r) begin
      mem_we = !placed_r;
    end
  end

  // Result for the next cycle, registered below.
  logic      out_strobe_nxt;
  out_item_t out_item_nxt;

  always_comb begin
    out_strobe_nxt = 1'b0;
    out_item_nxt = '0;
    unique case (state_r)
      S_QUERY: begin
        if (rd_idx_r >= count_r) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt.found = any_r || (rd_vld_r && hit);
          out_item_nxt.last = 1'b1;
        end
      end
      S_LIST: begin
        if (count_r == '0) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt.last = 1'b1;
        end else if (rd_vld_r) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt.entry_valid = 1'b1;
          out_item_nxt.range_low = m_lo;
          out_item_nxt.range_high = m_hi;
          out_item_nxt.last = (rd_idx_r == count_r);
        end
      end
      S_DONE: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt.status = (req_r == REQ_ADD || req_r == REQ_POINT) && flag_r;
        out_item_nxt.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_strobe <= 1'b0;
      out_item <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      out_strobe <= out_strobe_nxt;
      out_item <= out_item_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r <= in_item.req_type;
            rd_idx_r <= '0;
            rd_vld_r <= 1'b0;
            absorbed_r <= '0;
            changed_r <= 1'b0;
            any_r <= 1'b0;
            placed_r <= 1'b0;
            wr_idx_r <= '0;
            if (in_item.req_type == REQ_POINT) begin
              lo_r <= sat32(pt_lo);
              hi_r <= sat32(pt_hi);
            end else if (in_item.a_value < in_item.b_value) begin
              lo_r <= in_item.a_value;
              hi_r <= in_item.b_value;
            end else begin
              lo_r <= in_item.b_value;
              hi_r <= in_item.a_value;
            end
            unique case (in_item.req_type)
              REQ_ADD, REQ_POINT: state_r <= S_SCAN;
              REQ_QUERY: state_r <= S_QUERY;
              REQ_LIST: state_r <= S_LIST;
              REQ_CLEAR: begin
                count_r <= '0;
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          // Grow the hull; rescan until a whole pass absorbs nothing.
          if (absorb_now) begin
            absorbed_r[prev_idx] <= 1'b1;
            any_r <= 1'b1;
            if (m_lo < lo_r) lo_r <= m_lo;
            if (m_hi > hi_r) hi_r <= m_hi;
          end
          if (rd_idx_r < count_r) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_vld_r <= 1'b1;
            if (absorb_now) changed_r <= 1'b1;
          end else if (rd_vld_r) begin
            rd_vld_r <= 1'b0;
            rd_idx_r <= '0;
            changed_r <= 1'b0;
            if (!(changed_r || absorb_now)) begin
              if (!any_r && count_r == CntBits'(MaxIntervals)) begin
                flag_r <= 1'b1;
                state_r <= S_DONE;
              end else begin
                flag_r <= 1'b0;
                state_r <= S_PACK;
              end
            end
          end else begin
            rd_idx_r <= '0;
            flag_r <= 1'b0;
            state_r <= S_PACK;
          end
        end
        S_PACK: begin
          if (rd_vld_r) begin
            if (!absorbed_r[prev_idx]) wr_idx_r <= wr_idx_r + 1'b1;
            if (place_now) begin
              // Hull goes here; the held entry is written one slot up next cycle.
              placed_r <= 1'b1;
            end else if (rd_idx_r < count_r) begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end else begin
              rd_vld_r <= 1'b0;
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end else if (rd_idx_r < count_r) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_vld_r <= 1'b1;
          end else begin
            // Past the end: append the hull if not yet placed.
            count_r <= placed_r ? wr_idx_r : wr_idx_r + 1'b1;
            state_r <= S_DONE;
          end
        end
        S_QUERY: begin
          if (rd_vld_r && hit) any_r <= 1'b1;
          if (rd_idx_r < count_r) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_vld_r <= 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LIST: begin
          if (count_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            if (rd_vld_r && rd_idx_r == count_r) state_r <= S_IDLE;
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_vld_r <= 1'b1;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CISM_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CntBits'(MaxIntervals))
  `CISM_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe && !out_item.last, busy)
  `CISM_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `CISM_ASSERT_IMP(a_pack_order, clk, rst_n, state_r == S_PACK, wr_idx_r <= rd_idx_r)
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the closed interval set merger: a queued request driver,
// a result monitor and an interval table predictor. Depends on cism_pkg and the RTL top.
`default_nettype none
module tb_top;
  import cism_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;

  always #5 clk = ~clk;

  closed_interval_set_merger dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  // Predictor state: a sorted table of disjoint closed intervals.
  logic signed [31:0] tab_low [MaxIntervals];
  logic signed [31:0] tab_high [MaxIntervals];
  int tab_count = 0;

  in_item_t pending_reqs[$];
  out_item_t expected_results[$];
  int sender_idle_pct = 32;
  int error_count = 0;
  int result_count = 0;
  int transfers_sent = 0;
  int full_drops = 0;
  int hits = 0;
  longint cycle_count = 0;
  bit stim_done = 1'b0;

  function automatic void add_expected(out_item_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void queue_req(in_item_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  // Adds the hull of [lo, hi] and every touching interval; returns the drop flag.
  function automatic logic merge_interval(logic signed [31:0] lo, logic signed [31:0] hi);
    bit absorbed [MaxIntervals];
    logic signed [31:0] nl [MaxIntervals];
    logic signed [31:0] nh [MaxIntervals];
    bit changed, any, placed;
    int n;
    absorbed = '{default: 1'b0};
    changed = 1'b1;
    any = 1'b0;
    placed = 1'b0;
    n = 0;
    while (changed) begin
      changed = 1'b0;
      for (int k = 0; k < tab_count; k++) begin
        if (!absorbed[k] && tab_low[k] <= hi && lo <= tab_high[k]) begin
          absorbed[k] = 1'b1;
          any = 1'b1;
          changed = 1'b1;
          if (tab_low[k] < lo) lo = tab_low[k];
          if (tab_high[k] > hi) hi = tab_high[k];
        end
      end
    end
    if (!any && tab_count >= MaxIntervals) return 1'b1;
    for (int k = 0; k < tab_count; k++) begin
      if (!absorbed[k]) begin
        if (!placed && tab_low[k] > hi) begin
          nl[n] = lo; nh[n] = hi; n++;
          placed = 1'b1;
        end
        nl[n] = tab_low[k]; nh[n] = tab_high[k]; n++;
      end
    end
    if (!placed) begin
      nl[n] = lo; nh[n] = hi; n++;
    end
    for (int k = 0; k < n; k++) begin
      tab_low[k] = nl[k];
      tab_high[k] = nh[k];
    end
    tab_count = n;
    return 1'b0;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Works out and queues the results one accepted request causes.
  function automatic void predict_results(in_item_t req);
    out_item_t r;
    logic signed [31:0] lo, hi;
    longint centre;
    r = '0;
    r.last = 1'b1;
    lo = (req.a_value < req.b_value) ? req.a_value : req.b_value;
    hi = (req.a_value < req.b_value) ? req.b_value : req.a_value;
    case (req.req_type)
      REQ_ADD: begin
        r.status = merge_interval(lo, hi);
        add_expected(r);
      end
      REQ_POINT: begin
        centre = longint'(req.a_value) * 65536;
        r.status = merge_interval(sat32(centre - PointHalf), sat32(centre + PointHalf));
        add_expected(r);
      end
      REQ_QUERY: begin
        for (int k = 0; k < tab_count; k++)
          if (tab_low[k] <= hi && lo <= tab_high[k]) r.found = 1'b1;
        add_expected(r);
      end
      REQ_CLEAR: begin
        tab_count = 0;
        add_expected(r);
      end
      REQ_LIST: begin
        if (tab_count == 0) add_expected(r);
        for (int k = 0; k < tab_count; k++) begin
          r.entry_valid = 1'b1;
          r.range_low = tab_low[k];
          r.range_high = tab_high[k];
          r.last = (k == tab_count - 1);
          add_expected(r);
        end
      end
      default: add_expected(r);
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Driver: a request is transferred at an edge with start high and busy low.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) begin
        predict_results(in_item);
        transfers_sent <= transfers_sent + 1;
        void'(pending_reqs.pop_front());
      end
      if ((!start || !busy) && pending_reqs.size() > 0
          && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_item <= pending_reqs[0];
      end else if (start && !busy) begin
        start <= 1'b0;
        in_item <= '0;
      end
    end
  end

  // Monitor: every strobe is one result transfer, checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      result_count <= result_count + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        automatic out_item_t e = expected_results.pop_front();
        if (out_item.status !== e.status) report_mismatch("status");
        if (out_item.found !== e.found) report_mismatch("found");
        if (out_item.entry_valid !== e.entry_valid) report_mismatch("entry_valid");
        if (out_item.range_low !== e.range_low) report_mismatch("range_low");
        if (out_item.range_high !== e.range_high) report_mismatch("range_high");
        if (out_item.last !== e.last) report_mismatch("last");
        if (e.status) full_drops++;
        if (e.found) hits++;
      end
    end
  end

  function automatic in_item_t make_req(req_code_t t, logic [31:0] a, logic [31:0] b);
    in_item_t r;
    r.req_type = t;
    r.a_value = a;
    r.b_value = b;
    return r;
  endfunction

  // Random content drawn near a small window so intervals overlap, touch and merge.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(40)) - 20) <<< 16 | 32'($urandom_range(3) * 16384);
    endcase
  endfunction

  function automatic in_item_t rand_req();
    logic [31:0] a;
    int pick;
    a = rand_coord();
    pick = $urandom_range(99);
    if (pick < 40) return make_req(REQ_ADD, a, a + $urandom_range(200000));
    if (pick < 55) return make_req(REQ_POINT, $urandom_range(9) == 0 ? $urandom()
                                   : 32'(int'($urandom_range(40)) - 20), $urandom());
    if (pick < 75) return make_req(REQ_QUERY, a, $urandom_range(1) ? a : a - $urandom_range(70000));
    if (pick < 80) return make_req(REQ_CLEAR, $urandom(), $urandom());
    if (pick < 97) return make_req(REQ_LIST, $urandom(), $urandom());
    return make_req(req_code_t'(3'd5 + $urandom_range(2)), $urandom(), $urandom());
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || busy || start)
      @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, reversed endpoints, touching merge, point saturation,
    // unknown codes, empty list, and a full table that drops an add.
    queue_req(make_req(REQ_LIST, 0, 0));
    queue_req(make_req(REQ_QUERY, 0, 0));
    queue_req(make_req(REQ_ADD, 32'h00050000, 32'h00010000));
    queue_req(make_req(REQ_ADD, 32'h00050000, 32'h00080000));
    queue_req(make_req(REQ_ADD, 32'h80000000, 32'h80000000));
    queue_req(make_req(REQ_ADD, 32'h7fffffff, 32'h7ffffff0));
    queue_req(make_req(REQ_POINT, 32'h7fffffff, 32'hffffffff));
    queue_req(make_req(REQ_POINT, 32'h80000000, 0));
    queue_req(make_req(REQ_POINT, 32'd100, 0));
    queue_req(make_req(REQ_QUERY, 32'h00640000, 32'h00640000));
    queue_req(make_req(REQ_QUERY, 32'h00090000, 32'h00080001));
    queue_req(make_req(req_code_t'(3'd7), 32'hffffffff, 32'hffffffff));
    queue_req(make_req(REQ_LIST, 0, 0));
    for (int k = 0; k < 12; k++)
      queue_req(make_req(REQ_POINT, 32'(200 + 3 * k), 0));
    queue_req(make_req(REQ_POINT, 32'd300, 0));
    queue_req(make_req(REQ_ADD, 32'h00c80000, 32'h00ce0000));
    queue_req(make_req(REQ_LIST, 0, 0));
    queue_req(make_req(REQ_CLEAR, 0, 0));
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 79 : 0;
      for (int k = 0; k < 117; k++) queue_req(rand_req());
      drain();
    end
    repeat (60) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || cycle_count > 400000);
    if (!stim_done) begin
      $display("FAILURE");
      $finish;
    end else begin
      $display("Sent %0d requests and checked %0d results (%0d hits, %0d dropped adds).",
               transfers_sent, result_count, hits, full_drops);
      if (error_count == 0 && expected_results.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
    end
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/cism_pkg.sv
rtl/closed_interval_set_merger.sv
bench/tb_top.sv
